@@ rtl/rsx_pkg.sv @@
// ----------------------------------------------------------------------------
// rsx_pkg
// shared types, constants and sizes of the instruction execute core
// ----------------------------------------------------------------------------
package rsx_pkg;

  localparam int DATA_MEM_WORDS = 1024;   // power of two, index is a bit field
  localparam int DMEM_AW        = $clog2(DATA_MEM_WORDS);
  localparam int REG_COUNT      = 16;
  localparam int REG_AW         = $clog2(REG_COUNT);
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_AW       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [REG_AW-1:0] PC_REG   = 4'd15;
  localparam logic [REG_AW-1:0] LINK_REG = 4'd14;

  localparam logic [3:0] COND_ALWAYS  = 4'hE;
  localparam logic [3:0] MUL_PATTERN  = 4'b1001;
  localparam logic [3:0] OP_SUB       = 4'd2;
  localparam logic [3:0] OP_ADD       = 4'd4;
  localparam logic [3:0] SWI_PREFIX   = 4'hF;
  localparam logic [7:0] SWI_HALT_NUM = 8'h0A;

  localparam logic [1:0] CLS_DATA   = 2'b00;
  localparam logic [1:0] CLS_XFER   = 2'b01;
  localparam logic [1:0] CLS_BRANCH = 2'b10;
  localparam logic [1:0] CLS_SWI    = 2'b11;

  typedef enum logic [2:0] {
    K_NOP,
    K_MUL,
    K_ALU,
    K_LOAD,
    K_STORE,
    K_BRANCH,
    K_SWI
  } op_kind_t;

  // decoded instruction handed from the front end to the back end
  typedef struct packed {
    op_kind_t          kind;
    logic              flag_s;
    logic              sub;
    logic              up;
    logic              wb;
    logic              link;
    logic [REG_AW-1:0] ra;
    logic [REG_AW-1:0] rb;
    logic [REG_AW-1:0] rd;
    logic [REG_AW-1:0] rn;
    logic [31:0]       imm;
  } dec_t;

  // one result item
  typedef struct packed {
    logic [31:0]       next_pc;
    logic              dest_write;
    logic [REG_AW-1:0] dest_index;
    logic [31:0]       dest_value;
    logic              base_write;
    logic [REG_AW-1:0] base_index;
    logic [31:0]       base_value;
    logic              store_done;
    logic [31:0]       store_address;
    logic [31:0]       store_value;
    logic [1:0]        flags_nz;
    logic              halted;
  } res_t;

  typedef enum logic [2:0] {
    BK_RD,
    BK_EX,
    BK_LD,
    BK_WB2,
    BK_HOLD
  } bk_state_t;

endpackage

@@ rtl/rsx_ram.sv @@
// ----------------------------------------------------------------------------
// rsx_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module rsx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/rsx_front.sv @@
// ----------------------------------------------------------------------------
// rsx_front
// accepts instruction words, decodes them and queues them for execution
// ----------------------------------------------------------------------------
module rsx_front
  import rsx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instr,
  input  logic        hold_off,
  output logic        q_valid,
  output dec_t        q_item,
  input  logic        q_pop
);

  dec_t                dec_c;
  dec_t                q_mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;
  logic                push;
  logic [63:0]         rot_pair;
  logic [4:0]          rot_amt;

  // rotate by twice the 4-bit field
  assign rot_amt  = {in_instr[11:8], 1'b0};
  assign rot_pair = {24'd0, in_instr[7:0], 24'd0, in_instr[7:0]} >> rot_amt;

  always_comb begin
    dec_c      = '0;
    dec_c.kind = K_NOP;
    if (in_instr[31:28] == COND_ALWAYS) begin
      unique case (in_instr[27:26])
        CLS_DATA: begin
          if (in_instr[7:4] == MUL_PATTERN) begin
            if (!in_instr[21] && in_instr[19:16] != in_instr[3:0] &&
                in_instr[19:16] != PC_REG && in_instr[3:0] != PC_REG &&
                in_instr[11:8] != PC_REG) begin
              dec_c.kind   = K_MUL;
              dec_c.flag_s = in_instr[20];
              dec_c.rd     = in_instr[19:16];
              dec_c.ra     = in_instr[3:0];
              dec_c.rb     = in_instr[11:8];
            end
          end else if (in_instr[25] &&
                       (in_instr[24:21] == OP_SUB || in_instr[24:21] == OP_ADD)) begin
            dec_c.kind = K_ALU;
            dec_c.sub  = (in_instr[24:21] == OP_SUB);
            dec_c.ra   = in_instr[19:16];
            dec_c.rd   = in_instr[15:12];
            dec_c.imm  = rot_pair[31:0];
          end
        end
        CLS_XFER: begin
          if (!in_instr[25] && !in_instr[22]) begin
            dec_c.kind = in_instr[20] ? K_LOAD : K_STORE;
            dec_c.up   = in_instr[23];
            dec_c.wb   = in_instr[21];
            dec_c.rn   = in_instr[19:16];
            dec_c.rd   = in_instr[15:12];
            dec_c.ra   = in_instr[19:16];
            dec_c.rb   = in_instr[15:12];
            dec_c.imm  = {20'd0, in_instr[11:0]};
          end
        end
        CLS_BRANCH: begin
          dec_c.kind = K_BRANCH;
          dec_c.link = in_instr[24];
          dec_c.imm  = {{6{in_instr[23]}}, in_instr[23:0], 2'b00};
        end
        CLS_SWI: begin
          if (in_instr[27:24] == SWI_PREFIX && in_instr[7:0] == SWI_HALT_NUM) begin
            dec_c.kind = K_SWI;
          end
        end
      endcase
    end
  end

  assign in_ready = (count_r != QUEUE_CW'(QUEUE_DEPTH)) && !hold_off;
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && q_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/rsx_back.sv @@
// ----------------------------------------------------------------------------
// rsx_back
// executes decoded instructions against register file, flags and data memory
// ----------------------------------------------------------------------------
module rsx_back
  import rsx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  dec_t q_item,
  output logic q_pop,
  output logic busy,
  output logic res_valid,
  output res_t res,
  input  logic res_ready
);

  bk_state_t            state_r, state_nxt;
  logic                 clearing_r;
  logic [DMEM_AW-1:0]   clr_idx_r;
  logic [REG_COUNT-1:0] rf_valid_r;
  logic [31:0]          pc_r;
  logic [1:0]           flags_r;
  logic                 halt_r;
  dec_t                 cur_r;
  logic                 ok_a_r;
  logic                 ok_b_r;
  res_t                 res_r;

  logic [31:0]          rf_a_rdata, rf_b_rdata;
  logic                 rf_we;
  logic [REG_AW-1:0]    rf_waddr;
  logic [31:0]          rf_wdata;
  logic                 dm_we;
  logic [DMEM_AW-1:0]   dm_waddr;
  logic [31:0]          dm_wdata;
  logic [31:0]          dm_rdata;

  logic [31:0]          opa, opb, mul_lo, xfer_addr;
  logic                 is_load_go;
  res_t                 ex_c, ld_c;
  logic                 ex_final, ld_final;

  // two copies of the register file give two read ports
  rsx_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
    .clk     (clk),
    .wr_en   (rf_we),
    .wr_addr (rf_waddr),
    .wr_data (rf_wdata),
    .rd_addr (q_item.ra),
    .rd_data (rf_a_rdata)
  );

  rsx_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
    .clk     (clk),
    .wr_en   (rf_we),
    .wr_addr (rf_waddr),
    .wr_data (rf_wdata),
    .rd_addr (q_item.rb),
    .rd_data (rf_b_rdata)
  );

  rsx_ram #(.WIDTH(32), .DEPTH(DATA_MEM_WORDS)) u_dmem (
    .clk     (clk),
    .wr_en   (dm_we),
    .wr_addr (dm_waddr),
    .wr_data (dm_wdata),
    .rd_addr (xfer_addr[DMEM_AW+1:2]),
    .rd_data (dm_rdata)
  );

  // operands: r15 reads the pc, unwritten entries read zero
  assign opa = (cur_r.ra == PC_REG) ? pc_r : (ok_a_r ? rf_a_rdata : 32'd0);
  assign opb = (cur_r.rb == PC_REG) ? pc_r : (ok_b_r ? rf_b_rdata : 32'd0);

  assign mul_lo     = opa * opb;
  assign xfer_addr  = cur_r.up ? opa + cur_r.imm : opa - cur_r.imm;
  assign is_load_go = (cur_r.kind == K_LOAD) && !halt_r;

  // execute step
  always_comb begin
    ex_c          = '0;
    ex_c.next_pc  = pc_r + 32'd4;
    ex_c.flags_nz = flags_r;
    ex_c.halted   = halt_r;
    if (halt_r) begin
      ex_c.next_pc = pc_r;
    end else begin
      unique case (cur_r.kind)
        K_MUL: begin
          ex_c.dest_write = 1'b1;
          ex_c.dest_index = cur_r.rd;
          ex_c.dest_value = mul_lo;
          if (cur_r.flag_s) begin
            ex_c.flags_nz = {mul_lo[31], (mul_lo == 32'd0)};
          end
        end
        K_ALU: begin
          ex_c.dest_write = 1'b1;
          ex_c.dest_index = cur_r.rd;
          ex_c.dest_value = cur_r.sub ? opa - cur_r.imm : opa + cur_r.imm;
        end
        K_LOAD: begin
          // loaded value and its pc effect are filled in later, in the BK_LD state
          ex_c.dest_write = 1'b1;
          ex_c.dest_index = cur_r.rd;
        end
        K_STORE: begin
          ex_c.store_done    = 1'b1;
          ex_c.store_address = xfer_addr;
          ex_c.store_value   = opb;
        end
        K_BRANCH: begin
          ex_c.next_pc = pc_r + 32'd8 + cur_r.imm;
          if (cur_r.link) begin
            ex_c.dest_write = 1'b1;
            ex_c.dest_index = LINK_REG;
            ex_c.dest_value = pc_r;
          end
        end
        K_SWI: begin
          ex_c.halted = 1'b1;
        end
        K_NOP: begin
        end
        default: begin
        end
      endcase
      if ((cur_r.kind == K_LOAD || cur_r.kind == K_STORE) && cur_r.wb) begin
        ex_c.base_write = 1'b1;
        ex_c.base_index = cur_r.rn;
        ex_c.base_value = xfer_addr;
      end
      if (ex_c.dest_write && ex_c.dest_index == PC_REG && cur_r.kind != K_LOAD) begin
        ex_c.next_pc = ex_c.dest_value;
      end
      if (ex_c.base_write && ex_c.base_index == PC_REG) begin
        ex_c.next_pc = ex_c.base_value;
      end
    end
  end

  // load completion: base writeback to r15 still wins over the loaded value
  always_comb begin
    ld_c            = res_r;
    ld_c.dest_value = dm_rdata;
    if (res_r.dest_index == PC_REG &&
        !(res_r.base_write && res_r.base_index == PC_REG)) begin
      ld_c.next_pc = dm_rdata;
    end
  end

  assign ex_final = (state_r == BK_EX) && !is_load_go;
  assign ld_final = (state_r == BK_LD) && !res_r.base_write;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_RD:   if (q_pop) state_nxt = BK_EX;
      BK_EX: begin
        if (is_load_go)     state_nxt = BK_LD;
        else if (res_ready) state_nxt = BK_RD;
        else                state_nxt = BK_HOLD;
      end
      BK_LD: begin
        if (res_r.base_write) state_nxt = BK_WB2;
        else if (res_ready)   state_nxt = BK_RD;
        else                  state_nxt = BK_HOLD;
      end
      BK_WB2:  state_nxt = res_ready ? BK_RD : BK_HOLD;
      BK_HOLD: if (res_ready) state_nxt = BK_RD;
      default: state_nxt = BK_RD;
    endcase
  end

  // outputs and write ports
  always_comb begin
    q_pop     = (state_r == BK_RD) && q_valid && !clearing_r;
    busy      = clearing_r;
    res_valid = ex_final || ld_final || (state_r == BK_WB2) || (state_r == BK_HOLD);
    res       = res_r;
    rf_we     = 1'b0;
    rf_waddr  = ex_c.dest_index;
    rf_wdata  = ex_c.dest_value;
    unique case (state_r)
      BK_EX: begin
        res = ex_c;
        if (!halt_r) begin
          if (ex_c.base_write && cur_r.kind == K_STORE) begin
            rf_we    = 1'b1;
            rf_waddr = ex_c.base_index;
            rf_wdata = ex_c.base_value;
          end else if (ex_c.dest_write && cur_r.kind != K_LOAD) begin
            rf_we = 1'b1;
          end
        end
      end
      BK_LD: begin
        res      = ld_c;
        rf_we    = 1'b1;
        rf_waddr = res_r.dest_index;
        rf_wdata = dm_rdata;
      end
      BK_WB2: begin
        rf_we    = 1'b1;
        rf_waddr = res_r.base_index;
        rf_wdata = res_r.base_value;
      end
      BK_RD, BK_HOLD: begin
      end
      default: begin
      end
    endcase
    dm_we    = clearing_r || ((state_r == BK_EX) && !halt_r && cur_r.kind == K_STORE);
    dm_waddr = clearing_r ? clr_idx_r : xfer_addr[DMEM_AW+1:2];
    dm_wdata = clearing_r ? 32'd0 : opb;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r  <= q_item;
      ok_a_r <= rf_valid_r[q_item.ra];
      ok_b_r <= rf_valid_r[q_item.rb];
    end
    if (state_r == BK_EX) begin
      res_r <= ex_c;
    end else if (state_r == BK_LD) begin
      res_r <= ld_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_RD;
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
      rf_valid_r <= '0;
      pc_r       <= '0;
      flags_r    <= '0;
      halt_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == DMEM_AW'(DATA_MEM_WORDS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (rf_we) begin
        rf_valid_r[rf_waddr] <= 1'b1;
      end
      if (state_r == BK_EX) begin
        flags_r <= ex_c.flags_nz;
        halt_r  <= ex_c.halted;
        pc_r    <= ex_c.next_pc;
      end else if (state_r == BK_LD) begin
        pc_r <= ld_c.next_pc;
      end
    end
  end

endmodule

@@ rtl/risc_subset_instruction_execute_core.sv @@
// ----------------------------------------------------------------------------
// risc_subset_instruction_execute_core
// executes one instruction word per input transfer and reports its effects
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_ready/in_instr carry the instruction word fetched at the pc;
//   out_valid/out_ready and the out_ fields carry one result transfer per
//   instruction, in order.
//   the front end decodes each word into a two-entry queue; the back end
//   reads the register file (registered read) and then executes.
//   the back end finishes one instruction before it takes the next: a
//   register file read, then execute and write-back; loads add a data
//   memory read, and loads with base writeback a second register write.
//   after reset the data memory is swept to zero, one word a cycle, over
//   all 1024 words (DATA_MEM_WORDS); in_ready stays low during the sweep.
//   if the receiver stalls, one result sits in the output register, one
//   more is held in the back end and the queue keeps taking transfers
//   until it is full.
// ----------------------------------------------------------------------------
module risc_subset_instruction_execute_core
  import rsx_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_instr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_next_pc,
  output logic              out_dest_write,
  output logic [REG_AW-1:0] out_dest_index,
  output logic [31:0]       out_dest_value,
  output logic              out_base_write,
  output logic [REG_AW-1:0] out_base_index,
  output logic [31:0]       out_base_value,
  output logic              out_store_done,
  output logic [31:0]       out_store_address,
  output logic [31:0]       out_store_value,
  output logic [1:0]        out_flags_nz,
  output logic              out_halted
);

  logic q_valid;
  dec_t q_item;
  logic q_pop;
  logic busy;
  logic res_valid;
  res_t res;
  logic res_ready;

  logic out_valid_r;
  res_t out_res_r;

  // front end: decode and queue
  rsx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_instr (in_instr),
    .hold_off (busy),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // back end: register file, flags, data memory
  rsx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // output register, refilled in the same cycle that its content transfers
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_next_pc       = out_res_r.next_pc;
  assign out_dest_write    = out_res_r.dest_write;
  assign out_dest_index    = out_res_r.dest_index;
  assign out_dest_value    = out_res_r.dest_value;
  assign out_base_write    = out_res_r.base_write;
  assign out_base_index    = out_res_r.base_index;
  assign out_base_value    = out_res_r.base_value;
  assign out_store_done    = out_res_r.store_done;
  assign out_store_address = out_res_r.store_address;
  assign out_store_value   = out_res_r.store_value;
  assign out_flags_nz      = out_res_r.flags_nz;
  assign out_halted        = out_res_r.halted;

endmodule
